### hw/rtl/spq_pkg.sv
// Package for the stable priority queue: default sizes, request kinds,
// result status codes and the per-cycle cell operation struct.
// No dependencies.
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int VALUE_BITS_DEF    = 16;
	localparam int PRIORITY_BITS_DEF = 4;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// operation applied to every cell at the same clock edge
	typedef struct packed {
		logic push;
		logic pop;
	} spq_op_t;

endpackage

### hw/rtl/spq_ifs.sv
// Valid/ready channel interfaces for the stable priority queue:
// request channel (push/pop) and result channel.
// Depends on spq_pkg.
interface spq_req_if #(
	parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [VALUE_BITS-1:0]    value;
	logic [PRIORITY_BITS-1:0] priority_req;

	modport source (output valid, kind, value, priority_req, input ready);
	modport sink   (input valid, kind, value, priority_req, output ready);
	modport mon    (input valid, ready, kind, value, priority_req);
endinterface

interface spq_rsp_if #(
	parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [VALUE_BITS-1:0]    popped_value;
	logic [PRIORITY_BITS-1:0] popped_priority;

	modport source (output valid, status, popped_value, popped_priority, input ready);
	modport sink   (input valid, status, popped_value, popped_priority, output ready);
	modport mon    (input valid, ready, status, popped_value, popped_priority);
endinterface

### hw/rtl/spq_cell.sv
// One slot of the sorted shift chain: holds one entry and decides each
// cycle whether to keep it, take the new entry, or take a neighbor's.
// Depends on spq_pkg.
module spq_cell #(
	parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spq_pkg::spq_op_t         op,
	input  logic [VALUE_BITS-1:0]    new_value,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic                     prev_after,
	input  logic                     prev_valid,
	input  logic [VALUE_BITS-1:0]    prev_value,
	input  logic [PRIORITY_BITS-1:0] prev_prio,
	input  logic                     next_valid,
	input  logic [VALUE_BITS-1:0]    next_value,
	input  logic [PRIORITY_BITS-1:0] next_prio,
	output logic                     after,
	output logic                     valid,
	output logic [VALUE_BITS-1:0]    value,
	output logic [PRIORITY_BITS-1:0] prio
);

	logic                     valid_q;
	logic [VALUE_BITS-1:0]    value_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	// new entry goes behind this one
	assign after = valid_q && (prio_q >= new_prio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.push && !after) begin
			valid_q <= prev_after ? 1'b1 : prev_valid;
		end else if (op.pop) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op.push && !after) begin
			value_q <= prev_after ? new_value : prev_value;
			prio_q  <= prev_after ? new_prio  : prev_prio;
		end else if (op.pop) begin
			value_q <= next_value;
			prio_q  <= next_prio;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign prio  = prio_q;

endmodule

### hw/rtl/stable_priority_queue.sv
// Stable priority queue top level: a chain of spq_cell slots kept in
// descending priority order, plus a registered result stage.
// Depends on spq_pkg, spq_ifs (spq_req_if, spq_rsp_if) and spq_cell.
//
//   channel | dir | fields                                    | beat
//   --------+-----+-------------------------------------------+-----------------
//   req     | in  | kind, value, priority_req                 | one push or pop
//   rsp     | out | status, popped_value, popped_priority     | one per request
//
// Every cell compares its priority with the new one and picks keep / new /
// shift at the same edge, so one request per cycle is sustained while rsp is
// not stalled. The result appears on rsp in the cycle after the request is
// taken. req.ready is low only while a result waits on a stalled rsp. Reset
// clears the valid bits of all cells and the result valid bit; the stored
// values and the result payload need no clearing.
module stable_priority_queue #(
	parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	// per-cell outputs, one entry per slot; slot 0 is the head
	logic [QUEUE_DEPTH-1:0]                    cell_after;
	logic [QUEUE_DEPTH-1:0]                    cell_valid;
	logic [QUEUE_DEPTH-1:0][VALUE_BITS-1:0]    cell_value;
	logic [QUEUE_DEPTH-1:0][PRIORITY_BITS-1:0] cell_prio;

	logic             take;
	logic             is_full;
	logic             is_empty;
	spq_pkg::spq_op_t op;

	logic                     rsp_valid_q;
	spq_pkg::status_t         status_q;
	logic [VALUE_BITS-1:0]    popped_value_q;
	logic [PRIORITY_BITS-1:0] popped_priority_q;

	// take a request whenever the result register is free or drains now
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;

	// valid bits stay contiguous from the head
	assign is_full  = cell_valid[QUEUE_DEPTH-1];
	assign is_empty = !cell_valid[0];

	// refused requests leave the chain untouched
	assign op.push = take && (req.kind == spq_pkg::KIND_PUSH) && !is_full;
	assign op.pop  = take && (req.kind == spq_pkg::KIND_POP) && !is_empty;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                     prev_after;
		logic                     prev_valid;
		logic [VALUE_BITS-1:0]    prev_value;
		logic [PRIORITY_BITS-1:0] prev_prio;
		logic                     next_valid;
		logic [VALUE_BITS-1:0]    next_value;
		logic [PRIORITY_BITS-1:0] next_prio;

		if (i == 0) begin : g_head
			// on a push the head takes the new entry whenever it does not keep its own
			assign prev_after = 1'b1;
			assign prev_valid = 1'b0;
			assign prev_value = '0;
			assign prev_prio  = '0;
		end else begin : g_body
			assign prev_after = cell_after[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_value = cell_value[i-1];
			assign prev_prio  = cell_prio[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			// tail drains to empty on a pop
			assign next_valid = 1'b0;
			assign next_value = '0;
			assign next_prio  = '0;
		end else begin : g_inner
			assign next_valid = cell_valid[i+1];
			assign next_value = cell_value[i+1];
			assign next_prio  = cell_prio[i+1];
		end

		spq_cell #(
			.VALUE_BITS    (VALUE_BITS),
			.PRIORITY_BITS (PRIORITY_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.new_value  (req.value),
			.new_prio   (req.priority_req),
			.prev_after (prev_after),
			.prev_valid (prev_valid),
			.prev_value (prev_value),
			.prev_prio  (prev_prio),
			.next_valid (next_valid),
			.next_value (next_value),
			.next_prio  (next_prio),
			.after      (cell_after[i]),
			.valid      (cell_valid[i]),
			.value      (cell_value[i]),
			.prio       (cell_prio[i])
		);
	end

	// result register: load on every taken request, drop when delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (req.kind == spq_pkg::KIND_PUSH) begin
				status_q          <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
				popped_value_q    <= '0;
				popped_priority_q <= '0;
			end else if (is_empty) begin
				status_q          <= spq_pkg::ST_EMPTY;
				popped_value_q    <= '0;
				popped_priority_q <= '0;
			end else begin
				status_q          <= spq_pkg::ST_DONE;
				popped_value_q    <= cell_value[0];
				popped_priority_q <= cell_prio[0];
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.popped_value    = popped_value_q;
	assign rsp.popped_priority = popped_priority_q;

endmodule

### hw/rtl/spq_checker.sv
// Port-level checks for stable_priority_queue, attached by bind.
// Depends on spq_pkg.
module spq_checker #(
	parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [1:0]               rsp_status,
	input logic [VALUE_BITS-1:0]    rsp_popped_value,
	input logic [PRIORITY_BITS-1:0] rsp_popped_priority
);

	// a stalled result holds its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_popped_value) && $stable(rsp_popped_priority))
		else $error("result changed while stalled");

	// every taken request shows a result in the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("request taken without a result");

	// refused or empty requests carry zero payload
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != spq_pkg::ST_DONE
			|-> rsp_popped_value == '0 && rsp_popped_priority == '0)
		else $error("nonzero payload on failed request");

	// status stays within the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == spq_pkg::ST_DONE || rsp_status == spq_pkg::ST_EMPTY
			|| rsp_status == spq_pkg::ST_FULL)
		else $error("undefined status code");

	// with no pending result the queue always takes a request
	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request blocked with empty result stage");

endmodule

bind stable_priority_queue spq_checker #(
	.VALUE_BITS    (VALUE_BITS),
	.PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_popped_value    (rsp.popped_value),
	.rsp_popped_priority (rsp.popped_priority)
);
